// ===== hdl/tpvc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpvc_pkg : shared types and codes of the two-product vend controller
// Holds command, button and mode codes, the register map and the bundles
// passed between the register file, the step logic and the top level.
// ----------------------------------------------------------------------------
package tpvc_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Commands carried by an input item
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_COIN   = 3'd1;
    localparam logic [2:0] CMD_EMPTY  = 3'd2;
    localparam logic [2:0] CMD_BUTTON = 3'd3;
    localparam logic [2:0] CMD_TICK   = 3'd4;

    // Buttons
    localparam logic [1:0] BTN_ONE    = 2'd0;
    localparam logic [1:0] BTN_TWO    = 2'd1;
    localparam logic [1:0] BTN_REFUND = 2'd2;

    // Modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READY = 2'd1;
    localparam logic [1:0] MODE_DISP  = 2'd2;

    // Products
    localparam logic [1:0] PROD_OFF = 2'd0;
    localparam logic [1:0] PROD_ONE = 2'd1;
    localparam logic [1:0] PROD_TWO = 2'd2;

    // Pending flag bits
    localparam int unsigned PEND_ONE    = 0;
    localparam int unsigned PEND_TWO    = 1;
    localparam int unsigned PEND_REFUND = 2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PRICE_ONE = 2'd0;
    localparam logic [1:0] REG_PRICE_TWO = 2'd1;
    localparam logic [1:0] REG_TIME_ONE  = 2'd2;
    localparam logic [1:0] REG_TIME_TWO  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] price_one;
        logic [DATA_W-1:0] price_two;
        logic [DATA_W-1:0] time_one;
        logic [DATA_W-1:0] time_two;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] countdown;
        logic [1:0]        active_product;
        logic [2:0]        pending;
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [1:0]        button;
        logic [DATA_W-1:0] balance;
    } t_item;

    typedef struct packed {
        logic [1:0]        state_code;
        logic              relay_one;
        logic              relay_two;
        logic [1:0]        charge_product;
        logic [DATA_W-1:0] charge_amount;
        logic              refund_request;
        logic [DATA_W-1:0] refund_amount;
        logic [1:0]        sale_finished;
        logic [DATA_W-1:0] seconds_left;
    } t_result;

endpackage

// ===== hdl/tpvc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tpvc_cfg_regs : price and dispense time registers
// APB-style register file for the four 16-bit settings, one word each.
// ----------------------------------------------------------------------------
module tpvc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output tpvc_pkg::t_cfg                o_cfg
);
    import tpvc_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic [DATA_W-1:0] rd_word;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_PRICE_ONE: n_cfg.price_one = pwdata[DATA_W-1:0];
                REG_PRICE_TWO: n_cfg.price_two = pwdata[DATA_W-1:0];
                REG_TIME_ONE:  n_cfg.time_one  = pwdata[DATA_W-1:0];
                REG_TIME_TWO:  n_cfg.time_two  = pwdata[DATA_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PRICE_ONE: rd_word = r_cfg.price_one;
            REG_PRICE_TWO: rd_word = r_cfg.price_two;
            REG_TIME_ONE:  rd_word = r_cfg.time_one;
            REG_TIME_TWO:  rd_word = r_cfg.time_two;
            default:       rd_word = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-DATA_W){1'b0}}, rd_word};
    assign o_cfg  = r_cfg;

endmodule

// ===== hdl/tpvc_step.sv =====
// ----------------------------------------------------------------------------
// tpvc_step : next-state and result logic for one item
// Applies the event to the mode, then runs the task rule of the new mode.
// ----------------------------------------------------------------------------
module tpvc_step (
    input  tpvc_pkg::t_cfg    i_cfg,
    input  tpvc_pkg::t_state  i_state,
    input  tpvc_pkg::t_item   i_item,
    output tpvc_pkg::t_state  o_state,
    output tpvc_pkg::t_result o_result
);
    import tpvc_pkg::*;

    logic [2:0] ev_pending;
    logic [1:0] ev_mode;
    logic       afford_one;
    logic       afford_two;
    t_state     nx;
    t_result    res;

    assign afford_one = i_item.balance >= i_cfg.price_one;
    assign afford_two = i_item.balance >= i_cfg.price_two;

    // Event phase: latch presses, move the mode on coin / credit empty
    always_comb begin
        ev_pending = i_state.pending;
        if (i_item.cmd == CMD_BUTTON) begin
            case (i_item.button)
                BTN_ONE:    ev_pending[PEND_ONE]    = 1'b1;
                BTN_TWO:    ev_pending[PEND_TWO]    = 1'b1;
                BTN_REFUND: ev_pending[PEND_REFUND] = 1'b1;
                default:    ev_pending = i_state.pending;
            endcase
        end
        ev_mode = i_state.mode;
        if (i_state.mode == MODE_IDLE && i_item.cmd == CMD_COIN) begin
            ev_mode = MODE_READY;
        end else if (i_state.mode == MODE_READY && i_item.cmd == CMD_EMPTY) begin
            ev_mode = MODE_IDLE;
        end
    end

    // Task phase
    always_comb begin
        nx                 = i_state;
        nx.mode            = ev_mode;
        nx.pending         = ev_pending;
        res                = '0;
        case (ev_mode)
            MODE_IDLE: begin
                nx.pending = '0;
            end
            MODE_READY: begin
                if (ev_pending[PEND_ONE] && afford_one) begin
                    nx.pending[PEND_ONE] = 1'b0;
                    nx.countdown         = i_cfg.time_one;
                    nx.active_product    = PROD_ONE;
                    nx.mode              = MODE_DISP;
                    res.charge_product   = PROD_ONE;
                    res.charge_amount    = i_cfg.price_one;
                end else if (ev_pending[PEND_TWO] && afford_two) begin
                    nx.pending[PEND_TWO] = 1'b0;
                    nx.countdown         = i_cfg.time_two;
                    nx.active_product    = PROD_TWO;
                    nx.mode              = MODE_DISP;
                    res.charge_product   = PROD_TWO;
                    res.charge_amount    = i_cfg.price_two;
                end else if (ev_pending[PEND_REFUND]) begin
                    nx.pending[PEND_REFUND] = 1'b0;
                    nx.mode                 = MODE_IDLE;
                    res.refund_request      = 1'b1;
                    res.refund_amount       = i_item.balance;
                end
            end
            MODE_DISP: begin
                if (i_item.cmd == CMD_TICK) begin
                    if (i_state.countdown != '0) begin
                        nx.countdown = i_state.countdown - 1'b1;
                    end else begin
                        res.sale_finished = i_state.active_product;
                        nx.active_product = PROD_OFF;
                        nx.mode           = MODE_IDLE;
                    end
                end
            end
            default: begin
                nx.mode = ev_mode;
            end
        endcase
        res.state_code   = nx.mode;
        res.relay_one    = (nx.mode == MODE_DISP) && (nx.active_product == PROD_ONE);
        res.relay_two    = (nx.mode == MODE_DISP) && (nx.active_product == PROD_TWO);
        res.seconds_left = nx.countdown;
    end

    assign o_state  = nx;
    assign o_result = res;

endmodule

// ===== hdl/two_product_vend_controller.sv =====
// ----------------------------------------------------------------------------
// two_product_vend_controller : two-product dispenser controller
// Input register, one pass of next-state logic, result register.
// ----------------------------------------------------------------------------
// Each input transfer carries an event (coin, credit empty, button press or
// second tick) plus the customer balance and yields exactly one result
// transfer: mode, relay drives, any charge or refund, a finished sale and the
// remaining dispense seconds. An item is captured in the input register and
// runs through one level of next-state logic as it moves to the result
// register. The input register and the result register each hold one item,
// so one item per cycle is sustained while every result is taken at once; a
// new input transfer is taken while a result waits only if the input register
// is empty. The controller state advances in the same cycle an item enters the
// result register. Prices and dispense times sit in four 16-bit registers on
// the APB-style port at byte offsets 0 (price one), 4 (price two), 8 (time one)
// and 12 (time two); write them only while no item is in flight.
// ----------------------------------------------------------------------------
module two_product_vend_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_cmd,
    input  logic [1:0]                    i_button,
    input  logic [tpvc_pkg::DATA_W-1:0]   i_balance,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_state_code,
    output logic                          o_relay_one,
    output logic                          o_relay_two,
    output logic [1:0]                    o_charge_product,
    output logic [tpvc_pkg::DATA_W-1:0]   o_charge_amount,
    output logic                          o_refund_request,
    output logic [tpvc_pkg::DATA_W-1:0]   o_refund_amount,
    output logic [1:0]                    o_sale_finished,
    output logic [tpvc_pkg::DATA_W-1:0]   o_seconds_left,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [tpvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [tpvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import tpvc_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  step_state;
    t_result step_result;

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_result;

    logic    in_xfer;
    logic    advance;

    tpvc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tpvc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (step_state),
        .o_result (step_result)
    );

    // Move the held item on when the result register is free or being emptied
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Input register: hold the item until it can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.cmd     <= i_cmd;
            r_item.button  <= i_button;
            r_item.balance <= i_balance;
        end
    end

    // Controller state: update once per item, as it enters the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= step_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_state_code     = r_result.state_code;
    assign o_relay_one      = r_result.relay_one;
    assign o_relay_two      = r_result.relay_two;
    assign o_charge_product = r_result.charge_product;
    assign o_charge_amount  = r_result.charge_amount;
    assign o_refund_request = r_result.refund_request;
    assign o_refund_amount  = r_result.refund_amount;
    assign o_sale_finished  = r_result.sale_finished;
    assign o_seconds_left   = r_result.seconds_left;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the two-product vend controller
// Drives event items with random gaps, predicts every result with a local
// copy of the controller state, and compares each result transfer field by
// field. Prices and dispense times change between phases over the APB port.
// ----------------------------------------------------------------------------
module tb_top;

    import tpvc_pkg::*;

    // Codes outside the defined command and button sets
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [1:0] BTN_UNUSED   = 2'd3;

    localparam int unsigned RAND_PHASES   = 7;
    localparam int unsigned PHASE_ITEMS   = 250;
    localparam int unsigned IDLE_PCT      = 11;
    localparam int unsigned HOLD_AT       = 400;   // results seen before the long hold
    localparam int unsigned HOLD_LEN      = 80;
    localparam int unsigned QUIET_FROM    = 900;   // stretch with no random idling
    localparam int unsigned QUIET_TO      = 1200;
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transfer at all

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic [2:0]                 i_cmd       = CMD_NONE;
    logic [1:0]                 i_button    = BTN_ONE;
    logic [DATA_W-1:0]          i_balance   = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [1:0]                 o_state_code;
    logic                       o_relay_one;
    logic                       o_relay_two;
    logic [1:0]                 o_charge_product;
    logic [DATA_W-1:0]          o_charge_amount;
    logic                       o_refund_request;
    logic [DATA_W-1:0]          o_refund_amount;
    logic [1:0]                 o_sale_finished;
    logic [DATA_W-1:0]          o_seconds_left;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [PADDR_W-1:0]         paddr       = '0;
    logic [PDATA_W-1:0]         pwdata      = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    two_product_vend_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_button         (i_button),
        .i_balance        (i_balance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_state_code     (o_state_code),
        .o_relay_one      (o_relay_one),
        .o_relay_two      (o_relay_two),
        .o_charge_product (o_charge_product),
        .o_charge_amount  (o_charge_amount),
        .o_refund_request (o_refund_request),
        .o_refund_amount  (o_refund_amount),
        .o_sale_finished  (o_sale_finished),
        .o_seconds_left   (o_seconds_left),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow controller: prices/times as written, plus the vend state
    // ------------------------------------------------------------------------
    t_cfg              cfg_now    = '0;
    logic [1:0]        vend_mode  = MODE_IDLE;
    logic [DATA_W-1:0] secs_left  = '0;
    logic [1:0]        vend_prod  = PROD_OFF;
    logic [2:0]        pend_bits  = '0;

    // Work out the result of one item and advance the shadow state. The event
    // lands first (press flag, coin or credit empty), then the mode task runs.
    function automatic t_result vend_step(logic [2:0] cmd, logic [1:0] btn,
                                          logic [DATA_W-1:0] bal);
        t_result r;
        r = '0;
        // a press is latched in any mode; the idle task wipes it below
        if (cmd == CMD_BUTTON && btn != BTN_UNUSED)
            pend_bits[btn] = 1'b1;
        if (vend_mode == MODE_IDLE && cmd == CMD_COIN)
            vend_mode = MODE_READY;
        else if (vend_mode == MODE_READY && cmd == CMD_EMPTY)
            vend_mode = MODE_IDLE;

        case (vend_mode)
            MODE_IDLE: begin
                pend_bits = '0;
            end
            MODE_READY: begin
                // fixed priority; an unaffordable press stays latched and
                // the next flag down still gets its turn
                if (pend_bits[PEND_ONE] && bal >= cfg_now.price_one) begin
                    pend_bits[PEND_ONE] = 1'b0;
                    secs_left           = cfg_now.time_one;
                    vend_prod           = PROD_ONE;
                    r.charge_product    = PROD_ONE;
                    r.charge_amount     = cfg_now.price_one;
                    vend_mode           = MODE_DISP;
                end else if (pend_bits[PEND_TWO] && bal >= cfg_now.price_two) begin
                    pend_bits[PEND_TWO] = 1'b0;
                    secs_left           = cfg_now.time_two;
                    vend_prod           = PROD_TWO;
                    r.charge_product    = PROD_TWO;
                    r.charge_amount     = cfg_now.price_two;
                    vend_mode           = MODE_DISP;
                end else if (pend_bits[PEND_REFUND]) begin
                    pend_bits[PEND_REFUND] = 1'b0;
                    r.refund_request       = 1'b1;
                    r.refund_amount        = bal;
                    vend_mode              = MODE_IDLE;
                end
            end
            MODE_DISP: begin
                if (cmd == CMD_TICK) begin
                    if (secs_left != '0) begin
                        secs_left = secs_left - 1'b1;
                    end else begin
                        r.sale_finished = vend_prod;
                        vend_prod       = PROD_OFF;
                        vend_mode       = MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase

        r.state_code   = vend_mode;
        r.relay_one    = (vend_mode == MODE_DISP) && (vend_prod == PROD_ONE);
        r.relay_two    = (vend_mode == MODE_DISP) && (vend_prod == PROD_TWO);
        r.seconds_left = secs_left;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the processes
    // ------------------------------------------------------------------------
    t_item       item_backlog[$];   // items not yet offered to the DUT
    t_result     due_results[$];    // predictions waiting for their result
    int unsigned n_sent    = 0;     // items put in the backlog
    int unsigned n_checked = 0;     // results matched against a prediction
    int unsigned n_errors  = 0;
    bit          in_took   = 1'b0;  // input transfer at the last rising edge

    function automatic bit quiet_stretch();
        return (n_checked >= QUIET_FROM) && (n_checked < QUIET_TO);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: change payload at the falling edge, hold it until the transfer
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : tx_side
        t_item nx;
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (item_backlog.size() > 0 &&
                (quiet_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nx = item_backlog.pop_front();
                i_in_valid <= 1'b1;
                i_cmd      <= nx.cmd;
                i_button   <= nx.button;
                i_balance  <= nx.balance;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold that the receiver
    // counts out itself, so the DUT fills up and drops o_in_ready
    // ------------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge i_clk) begin : rx_side
        logic take;
        if (!i_rst_n) begin
            take = 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            take      = 1'b0;
        end else if (!hold_done && n_checked >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            take      = 1'b0;
        end else if (quiet_stretch()) begin
            take = 1'b1;
        end else begin
            take = ($urandom_range(0, 99) >= IDLE_PCT);
        end
        i_out_ready <= take;
    end

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge check a result transfer against the oldest
    // prediction, then predict for an input transfer taken at the same edge
    // ------------------------------------------------------------------------
    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            in_took = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("state_code",     want.state_code,     o_state_code);
                    check_field("relay_one",      want.relay_one,      o_relay_one);
                    check_field("relay_two",      want.relay_two,      o_relay_two);
                    check_field("charge_product", want.charge_product, o_charge_product);
                    check_field("charge_amount",  want.charge_amount,  o_charge_amount);
                    check_field("refund_request", want.refund_request, o_refund_request);
                    check_field("refund_amount",  want.refund_amount,  o_refund_amount);
                    check_field("sale_finished",  want.sale_finished,  o_sale_finished);
                    check_field("seconds_left",   want.seconds_left,   o_seconds_left);
                    n_checked++;
                end
            end
            in_took = i_in_valid && o_in_ready;
            if (in_took)
                due_results.push_back(vend_step(i_cmd, i_button, i_balance));
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    initial begin : watchdog
        int unsigned dull;
        dull = 0;
        while (dull < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                dull = 0;
            else
                dull++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_item(logic [2:0] cmd, logic [1:0] btn, logic [DATA_W-1:0] bal);
        t_item it;
        it.cmd     = cmd;
        it.button  = btn;
        it.balance = bal;
        item_backlog.push_back(it);
        n_sent++;
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // rising edge inside the access cycle (pready is always high).
    task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(PDATA_W-DATA_W){1'b0}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRICE_ONE: cfg_now.price_one = val;
            REG_PRICE_TWO: cfg_now.price_two = val;
            REG_TIME_ONE:  cfg_now.time_one  = val;
            REG_TIME_TWO:  cfg_now.time_two  = val;
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [DATA_W-1:0] p1, logic [DATA_W-1:0] p2,
                                logic [DATA_W-1:0] t1, logic [DATA_W-1:0] t2);
        reg_write(REG_PRICE_ONE, p1);
        reg_write(REG_PRICE_TWO, p2);
        reg_write(REG_TIME_ONE,  t1);
        reg_write(REG_TIME_TWO,  t2);
        @(posedge i_clk);
    endtask

    // Hold until every queued item has come back as a checked result
    task automatic wait_drained();
        do @(negedge i_clk);
        while (item_backlog.size() != 0 || n_checked != n_sent);
    endtask

    function automatic logic [DATA_W-1:0] pick_price();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'($urandom_range(1, 300));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_secs();
        if ($urandom_range(0, 7) == 0)
            return DATA_W'($urandom_range(5, 30));
        return DATA_W'($urandom_range(0, 4));
    endfunction

    // Balances cluster on the affordability edge of the current prices
    function automatic logic [DATA_W-1:0] pick_balance();
        logic [DATA_W-1:0] p;
        p = $urandom_range(0, 1) ? cfg_now.price_one : cfg_now.price_two;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return p;
            3:       return (p == '0) ? p : p - 1'b1;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Mostly purchase traffic (coins, presses, ticks) with some stray and
    // malformed events mixed in
    task automatic queue_random_item();
        int unsigned r;
        int unsigned b;
        logic [2:0]  cmd;
        logic [1:0]  btn;
        r = $urandom_range(0, 99);
        if (r < 22)      cmd = CMD_COIN;
        else if (r < 50) cmd = CMD_BUTTON;
        else if (r < 80) cmd = CMD_TICK;
        else if (r < 85) cmd = CMD_EMPTY;
        else if (r < 92) cmd = CMD_NONE;
        else             cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        b = $urandom_range(0, 9);
        if (b < 4)       btn = BTN_ONE;
        else if (b < 7)  btn = BTN_TWO;
        else if (b < 9)  btn = BTN_REFUND;
        else             btn = BTN_UNUSED;
        queue_item(cmd, btn, pick_balance());
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned ph;
        int unsigned k;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk through a full purchase cycle with the corner events in place
        load_setting(16'd100, 16'd200, 16'd2, 16'd1);
        queue_item(CMD_NONE,     BTN_ONE,    '0);
        queue_item(CMD_SPARE_LO, BTN_UNUSED, '1);       // unused command codes
        queue_item(CMD_SPARE_HI, BTN_REFUND, 16'h5A5A);
        queue_item(CMD_TICK,     BTN_ONE,    16'd7);    // tick while idle
        queue_item(CMD_BUTTON,   BTN_ONE,    16'd500);  // press in idle gets wiped
        queue_item(CMD_COIN,     BTN_ONE,    16'd0);
        queue_item(CMD_COIN,     BTN_TWO,    16'd0);    // second coin does nothing
        queue_item(CMD_BUTTON,   BTN_UNUSED, '1);       // unused button
        queue_item(CMD_BUTTON,   BTN_ONE,    16'd99);   // one short: stays pending
        queue_item(CMD_BUTTON,   BTN_TWO,    16'd150);  // enough for pending product one: it dispenses
        queue_item(CMD_BUTTON,   BTN_REFUND, 16'd150);  // refund stays latched while dispensing
        queue_item(CMD_COIN,     BTN_ONE,    16'd300);
        queue_item(CMD_BUTTON,   BTN_ONE,    '1);
        queue_item(CMD_EMPTY,    BTN_ONE,    '0);       // credit empty mid-dispense
        queue_item(CMD_TICK,     BTN_ONE,    '0);
        queue_item(CMD_TICK,     BTN_ONE,    '0);
        queue_item(CMD_TICK,     BTN_ONE,    '0);       // tick at zero ends the sale
        wait_drained();

        // Zero prices and times: always affordable, ends on the first tick
        load_setting('0, '0, '0, '0);
        queue_item(CMD_COIN,   BTN_ONE, '0);
        queue_item(CMD_BUTTON, BTN_TWO, '0);
        queue_item(CMD_TICK,   BTN_TWO, '0);
        wait_drained();

        // Top prices: one count short fails, full balance buys, and product
        // one wins over a pending product two
        load_setting('1, '1, 16'd1, '1);
        queue_item(CMD_COIN,   BTN_ONE, '1);
        queue_item(CMD_BUTTON, BTN_TWO, 16'hFFFE);
        queue_item(CMD_BUTTON, BTN_ONE, '1);
        queue_item(CMD_TICK,   BTN_ONE, '1);
        queue_item(CMD_TICK,   BTN_ONE, '1);
        wait_drained();

        // Random phases, a fresh price/time setting for each
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            load_setting(pick_price(), pick_price(), pick_secs(), pick_secs());
            for (k = 0; k < PHASE_ITEMS; k++)
                queue_random_item();
            wait_drained();
        end

        // Allow for the two-stage pipeline before the verdict
        repeat (4) @(posedge i_clk);
        if (n_errors == 0 && due_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tpvc_pkg.sv
hdl/tpvc_cfg_regs.sv
hdl/tpvc_step.sv
hdl/two_product_vend_controller.sv
tb/tb_top.sv
